>>> design/vena_pkg.sv
`default_nettype none

package vena_pkg;

	// Fixed field widths
	localparam int unsigned DIFF_W  = 32;   // |a - b| never reaches 2^32
	localparam int unsigned L1_W    = 56;
	localparam int unsigned SQ_W    = 64;
	localparam int unsigned ROOT_W  = 32;
	localparam int unsigned MAX_W   = 33;
	localparam int unsigned WGT_W   = 24;
	localparam int unsigned OPND_W  = 64;
	localparam int unsigned PROD_W  = 128;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_WEIGHT_MODE = 1'b0;

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_LINEAR  = 2'd1,
		MODE_SQUARED = 2'd2
	} weight_mode_t;

	typedef enum logic [1:0] {
		MSEL_WW = 2'd0,   // weight * weight
		MSEL_DW = 2'd1,   // diff * factor
		MSEL_DD = 2'd2,   // diff * diff
		MSEL_SW = 2'd3    // square * factor
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WSQ_GO,
		S_WSQ_WAIT,
		S_L1_GO,
		S_L1_WAIT,
		S_SQ_GO,
		S_SQ_WAIT,
		S_SW_GO,
		S_SW_WAIT,
		S_ROOT_GO,
		S_ROOT_WAIT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     w_set;
		logic     l1_add;
		logic     sq_set;
		logic     sq_add;
		logic     root_start;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic need_wsq;
		logic last;
		logic mul_busy;
		logic root_busy;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> design/vena_mul.sv
`default_nettype none

module vena_mul
	import vena_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [OPND_W-1:0]   x,
	input  wire logic [OPND_W-1:0]   y,
	output logic                     busy,
	output logic [PROD_W-1:0]        prod
);

	localparam int unsigned HALF_W = OPND_W / 2;

	logic [OPND_W-1:0] x_q;
	logic [OPND_W-1:0] y_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic [OPND_W-1:0] pp_s1;
	logic [1:0]        sh_s1;
	logic [PROD_W-1:0] acc_q;

	logic [HALF_W-1:0] x_part;
	logic [HALF_W-1:0] y_part;
	logic [PROD_W-1:0] pp_aligned;

	// Partial products in order x0y0, x0y1, x1y0, x1y1
	assign x_part = cnt_q[1] ? x_q[OPND_W-1:HALF_W] : x_q[HALF_W-1:0];
	assign y_part = cnt_q[0] ? y_q[OPND_W-1:HALF_W] : y_q[HALF_W-1:0];

	always_comb begin
		case (sh_s1)
			2'd0:    pp_aligned = {{OPND_W{1'b0}}, pp_s1};
			2'd1:    pp_aligned = {{HALF_W{1'b0}}, pp_s1, {HALF_W{1'b0}}};
			2'd2:    pp_aligned = {pp_s1, {OPND_W{1'b0}}};
			default: pp_aligned = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd4) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_s1 <= OPND_W'(x_part) * OPND_W'(y_part);
				sh_s1 <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + pp_aligned;
			end
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

>>> design/vena_isqrt.sv
`default_nettype none

module vena_isqrt
	import vena_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SQ_W-1:0]   radicand,
	output logic                   busy,
	output logic [ROOT_W-1:0]      root
);

	localparam int unsigned CNT_W = $clog2(ROOT_W);
	localparam int unsigned REM_W = ROOT_W + 3;

	logic [SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	// One result bit per step: bring down two radicand bits, try 4*root+1
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1:SQ_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> design/vena_ctrl.sv
`default_nettype none

module vena_ctrl
	import vena_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.need_wsq ? S_WSQ_GO : S_L1_GO;
				end
			end
			S_WSQ_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_WW;
				state_d       = S_WSQ_WAIT;
			end
			S_WSQ_WAIT: begin
				if (!stat.mul_busy) begin
					cmd.w_set = 1'b1;
					state_d   = S_L1_GO;
				end
			end
			S_L1_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_DW;
				state_d       = S_L1_WAIT;
			end
			S_L1_WAIT: begin
				if (!stat.mul_busy) begin
					cmd.l1_add = 1'b1;
					state_d    = S_SQ_GO;
				end
			end
			S_SQ_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_DD;
				state_d       = S_SQ_WAIT;
			end
			S_SQ_WAIT: begin
				if (!stat.mul_busy) begin
					cmd.sq_set = 1'b1;
					state_d    = S_SW_GO;
				end
			end
			S_SW_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_SW;
				state_d       = S_SW_WAIT;
			end
			S_SW_WAIT: begin
				if (!stat.mul_busy) begin
					cmd.sq_add = 1'b1;
					state_d    = stat.last ? S_ROOT_GO : S_IDLE;
				end
			end
			S_ROOT_GO: begin
				cmd.root_start = 1'b1;
				state_d        = S_ROOT_WAIT;
			end
			S_ROOT_WAIT: begin
				// hold the root until the square root is done and the output register frees up
				if (!stat.root_busy && stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (!stat.mul_busy && !stat.root_busy))
		else $error("input taken while an arithmetic unit is busy");
`endif

endmodule

`default_nettype wire

>>> design/vena_datapath.sv
`default_nettype none

module vena_datapath
	import vena_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
)
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	output stat_t                           stat,
	input  wire logic [1:0]                 weight_mode,
	input  wire logic signed [DIFF_W-1:0]   value_a,
	input  wire logic signed [DIFF_W-1:0]   value_b,
	input  wire logic [WGT_W-1:0]           weight,
	input  wire logic                       last,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [L1_W-1:0]                 l1_norm,
	output logic [ROOT_W-1:0]               l2_norm,
	output logic [MAX_W-1:0]                max_norm
);

	// Factor width: covers weight, weight^2 >> F and 1.0
	localparam int unsigned WSQ_W = 2 * WGT_W - FRAC_BITS;
	localparam int unsigned W_W   = (WSQ_W > FRAC_BITS + 1) ? WSQ_W : FRAC_BITS + 1;

	logic [DIFF_W-1:0] d_q;
	logic [WGT_W-1:0]  wgt_q;
	logic [W_W-1:0]    w_q;
	logic              last_q;
	logic [SQ_W-1:0]   sq_q;
	logic [L1_W-1:0]   abs_sum_q;
	logic [SQ_W-1:0]   square_sum_q;
	logic [DIFF_W-1:0] peak_q;
	logic              out_valid_q;
	logic [L1_W-1:0]   l1_q;
	logic [ROOT_W-1:0] l2_q;
	logic [MAX_W-1:0]  max_q;

	logic [DIFF_W:0]   diff;
	logic [DIFF_W-1:0] d_in;
	logic [OPND_W-1:0] mul_x;
	logic [OPND_W-1:0] mul_y;
	logic              mul_busy;
	logic [PROD_W-1:0] prod;
	logic              root_busy;
	logic [ROOT_W-1:0] root;
	logic [L1_W-1:0]   l1_term;
	logic [L1_W:0]     l1_sum;
	logic [SQ_W-1:0]   sq_term;
	logic [SQ_W:0]     sq_sum;

	assign diff = {value_a[DIFF_W-1], value_a} - {value_b[DIFF_W-1], value_b};
	assign d_in = diff[DIFF_W] ? DIFF_W'(-diff) : diff[DIFF_W-1:0];

	always_comb begin
		case (cmd.mul_sel)
			MSEL_WW: begin
				mul_x = OPND_W'(wgt_q);
				mul_y = OPND_W'(wgt_q);
			end
			MSEL_DW: begin
				mul_x = OPND_W'(d_q);
				mul_y = OPND_W'(w_q);
			end
			MSEL_DD: begin
				mul_x = OPND_W'(d_q);
				mul_y = OPND_W'(d_q);
			end
			MSEL_SW: begin
				mul_x = sq_q;
				mul_y = OPND_W'(w_q);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	vena_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.busy   (mul_busy),
		.prod   (prod)
	);

	vena_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (square_sum_q),
		.busy     (root_busy),
		.root     (root)
	);

	// Scale products back by 2^F and clamp at the accumulator ceiling
	assign l1_term = (|prod[PROD_W-1:L1_W+FRAC_BITS]) ? '1 : prod[L1_W+FRAC_BITS-1:FRAC_BITS];
	assign l1_sum  = {1'b0, abs_sum_q} + {1'b0, l1_term};
	assign sq_term = (|prod[PROD_W-1:SQ_W+FRAC_BITS]) ? '1 : prod[SQ_W+FRAC_BITS-1:FRAC_BITS];
	assign sq_sum  = {1'b0, square_sum_q} + {1'b0, sq_term};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q    <= d_in;
			wgt_q  <= weight;
			last_q <= last;
			case (weight_mode)
				MODE_LINEAR: w_q <= W_W'(weight);
				default:     w_q <= W_W'(1) << FRAC_BITS;
			endcase
		end
		if (cmd.w_set) begin
			w_q <= W_W'(prod[2*WGT_W-1:FRAC_BITS]);
		end
		// d < 2^32, so d*d always fits 64 bits
		if (cmd.sq_set) begin
			sq_q <= prod[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_sum_q    <= '0;
			square_sum_q <= '0;
			peak_q       <= '0;
		end else if (cmd.emit) begin
			abs_sum_q    <= '0;
			square_sum_q <= '0;
			peak_q       <= '0;
		end else begin
			if (cmd.load && (d_in > peak_q)) begin
				peak_q <= d_in;
			end
			if (cmd.l1_add) begin
				abs_sum_q <= l1_sum[L1_W] ? '1 : l1_sum[L1_W-1:0];
			end
			if (cmd.sq_add) begin
				square_sum_q <= sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.emit | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			l1_q  <= abs_sum_q;
			l2_q  <= root;
			max_q <= MAX_W'(peak_q);
		end
	end

	assign stat.need_wsq  = (weight_mode == MODE_SQUARED);
	assign stat.last      = last_q;
	assign stat.mul_busy  = mul_busy;
	assign stat.root_busy = root_busy;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign l1_norm   = l1_q;
	assign l2_norm   = l2_q;
	assign max_norm  = max_q;

`ifndef ASSERT_OFF
	a_mul_not_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !mul_busy)
		else $error("multiplier restarted while busy");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (abs_sum_q == '0 && square_sum_q == '0 && peak_q == '0))
		else $error("accumulators not cleared after result");
`endif

endmodule

`default_nettype wire

>>> design/vector_error_norm_accumulator.sv
// Vector error norm accumulator: L1, L2 and Linf of a - b over a streamed range.
// Input channel: one element pair per transfer (value_a, value_b, weight, last),
// accepted when in_valid is high and in_stall is low. Raise last on the final
// element of the range; that transfer produces exactly one result.
// Output channel: l1_norm, l2_norm, max_norm with out_valid/out_stall; the
// result sits in an output register, so the block keeps taking elements while
// a finished result waits for the receiver.
// in_stall stays high until an element is done, so the block takes no new
// element mid-sequence. The shared 64x64 multiplier, built from four 32x32
// partial products, runs three products per element (four in squared mode).
// The last element adds the 32-step square root before its result is stored,
// and the store waits while out_stall holds the previous result; the next
// element waits until the result is stored.
// weight_mode sits at APB byte address 0; write it only while the block is idle.
// Reset clears the accumulators, the weight mode (no weight) and out_valid.
`default_nettype none

module vector_error_norm_accumulator
	import vena_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
)
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// APB configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [PADDR_W-1:0]         paddr,
	input  wire logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]              prdata,
	output logic                            pready,
	// element input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [DIFF_W-1:0]   value_a,
	input  wire logic signed [DIFF_W-1:0]   value_b,
	input  wire logic [WGT_W-1:0]           weight,
	input  wire logic                       last,
	// result output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [L1_W-1:0]                 l1_norm,
	output logic [ROOT_W-1:0]               l2_norm,
	output logic [MAX_W-1:0]                max_norm
);

	logic [1:0] weight_mode_q;
	logic       reg_sel;
	cmd_t       cmd;
	stat_t      stat;

	// Decode the word index; byte lanes within the word are ignored
	assign reg_sel = (paddr[2] == REG_WEIGHT_MODE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(weight_mode_q) : '0;

	// Mode 3 is kept as written and acts as no weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_mode_q <= MODE_NONE;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			weight_mode_q <= pwdata[1:0];
		end
	end

	// Sequence each element through the shared multiplier and square root
	vena_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Accumulators, operand registers and the output register
	vena_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.weight_mode (weight_mode_q),
		.value_a     (value_a),
		.value_b     (value_b),
		.weight      (weight),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.l1_norm     (l1_norm),
		.l2_norm     (l2_norm),
		.max_norm    (max_norm)
	);

`ifndef ASSERT_OFF
	a_no_result_without_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !last) |=> !cmd.emit)
		else $error("result emitted right after a non-final element");
`endif

endmodule

`default_nettype wire
